>>> hw/rtl/running_mean_variance_minmax_assert.svh
// Assertion macros for the running statistics block.
`ifndef RUNNING_MEAN_VARIANCE_MINMAX_ASSERT_SVH
`define RUNNING_MEAN_VARIANCE_MINMAX_ASSERT_SVH
// Implication checked on every edge outside reset.
`define RMV_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define RMV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> hw/rtl/rmvm_pkg.sv
// Package: types and constants of the running statistics block.
package rmvm_pkg;
  localparam int CountWidth = 32;
  localparam int FracBits = 16;

  typedef struct packed {
    logic signed [31:0] sample;
    logic restart;
  } rmvm_in_t;

  typedef struct packed {
    logic signed [31:0] mean_out;
    logic [47:0] variance_out;
    logic [31:0] stddev_out;
    logic signed [31:0] max_out;
    logic signed [31:0] min_out;
    logic [31:0] count_out;
  } rmvm_out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV1, ST_MEAN, ST_MUL, ST_ACC, ST_DIV2, ST_VSAT, ST_SQRT, ST_OUT
  } rmvm_state_t;

  typedef enum logic [1:0] {
    OP_DIV, OP_MUL, OP_SQRT
  } rmvm_op_t;

  typedef struct packed {
    logic start;
    rmvm_op_t op;
  } rmvm_cmd_t;
endpackage

>>> hw/rtl/rmvm_unit.sv
// Shared iterative unit: unsigned divide, multiply-shift and square root, one bit per cycle.
module rmvm_unit import rmvm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  rmvm_cmd_t   cmd,
  input  logic [63:0] opa,
  input  logic [63:0] opb,
  output logic        done,
  output logic [63:0] res
);
  rmvm_op_t op;
  logic busy;
  logic [6:0] cnt;
  logic [71:0] acc;
  logic [127:0] prod;
  logic [63:0] bval;
  logic [71:0] rem;
  logic [71:0] rad;
  logic [71:0] root;
  logic [72:0] rem_sh;
  logic [72:0] trial;
  logic [73:0] srem;
  logic [73:0] strial;

  always_comb begin
    rem_sh = {rem, acc[71]};
    trial = {9'd0, bval};
    srem = {rem[71:0], rad[71:70]};
    strial = {root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !cmd.start && busy && (cnt == 7'd1);
      if (cmd.start) begin
        busy <= 1'b1;
        op <= cmd.op;
        bval <= opb;
        rem <= '0;
        root <= '0;
        prod <= '0;
        acc <= {8'd0, opa};
        rad <= {opa, 8'd0} << (FracBits - 8);
        unique case (cmd.op)
          OP_DIV: cnt <= 7'd72;
          OP_MUL: cnt <= 7'd64;
          default: cnt <= 7'd36;
        endcase
      end else if (busy) begin
        unique case (op)
          OP_DIV: begin
            if (rem_sh >= trial) begin
              rem <= 72'(rem_sh - trial);
              acc <= {acc[70:0], 1'b1};
            end else begin
              rem <= rem_sh[71:0];
              acc <= {acc[70:0], 1'b0};
            end
          end
          OP_MUL: begin
            prod <= {prod[126:0], 1'b0} + (bval[63] ? {64'd0, acc[63:0]} : 128'd0);
            bval <= {bval[62:0], 1'b0};
          end
          default: begin
            rad <= {rad[69:0], 2'b00};
            if (srem >= strial) begin
              rem <= 72'(srem - strial);
              root <= {root[70:0], 1'b1};
            end else begin
              rem <= srem[71:0];
              root <= {root[70:0], 1'b0};
            end
          end
        endcase
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  logic [127:0] psh;
  always_comb begin
    psh = prod >> FracBits;
    unique case (op)
      OP_DIV: res = acc[63:0];
      OP_MUL: res = (psh[127:64] != 64'd0) ? {64{1'b1}} : psh[63:0];
      default: res = (root[71:32] != 40'd0) ? 64'h0000_0000_FFFF_FFFF : {32'd0, root[31:0]};
    endcase
  end
endmodule

>>> hw/rtl/running_mean_variance_minmax.sv
// Top level: Welford running mean, variance, stddev, max and min.
// channel | dir | payload    | handshake
// in      | in  | rmvm_in_t  | in_valid / in_stall
// out     | out | rmvm_out_t | out_valid / out_stall
// An item runs two 72-step divides, a 64-step multiply and
// a 36-step square root, all run one after the other in the shared unit.
// Restart items and first items skip both divides and the multiply.
// in_stall is high from acceptance until the result register is free again.
// Reset clears the statistics to zero; an out stall holds the result beat.
`include "running_mean_variance_minmax_assert.svh"
module running_mean_variance_minmax import rmvm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  rmvm_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output rmvm_out_t out_data
);
  localparam logic [CountWidth-1:0] CntMax = '1;

  rmvm_state_t state, state_next;
  logic [CountWidth-1:0] count;
  logic signed [63:0] mean;
  logic [63:0] ssd;
  logic signed [31:0] vmax, vmin;
  logic signed [63:0] x, d1;
  logic [63:0] var_r;
  rmvm_cmd_t cmd;
  logic [63:0] opa, opb, res;
  logic done;

  rmvm_unit u_unit (.clk, .rst, .cmd, .opa, .opb, .done, .res);

  logic signed [63:0] d2;
  logic [63:0] ad1, ad2;
  logic same_sign;
  logic [63:0] count64;
  always_comb begin
    d2 = x - mean;
    ad1 = d1[63] ? 64'(-d1) : d1;
    ad2 = d2[63] ? 64'(-d2) : d2;
    same_sign = !((d1 < 0 && d2 > 0) || (d1 > 0 && d2 < 0));
    count64 = 64'(count);
  end

  assign in_stall = (state != ST_IDLE) || out_valid;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '{start: 1'b0, op: OP_DIV};
    opa = '0;
    opb = '0;
    unique case (state)
      ST_IDLE: if (in_valid && !in_stall) state_next = ST_DIV1;
      ST_DIV1: begin
        if (count == CountWidth'(1)) state_next = ST_DIV2;
        else begin
          cmd = '{start: 1'b1, op: OP_DIV};
          opa = ad1;
          opb = count64;
          state_next = ST_MEAN;
        end
      end
      ST_MEAN: if (done) state_next = ST_MUL;
      ST_MUL: begin
        cmd = '{start: 1'b1, op: OP_MUL};
        opa = ad1;
        opb = ad2;
        state_next = ST_ACC;
      end
      ST_ACC: if (done) state_next = ST_DIV2;
      ST_DIV2: begin
        if (count < CountWidth'(2)) state_next = ST_VSAT;
        else begin
          cmd = '{start: 1'b1, op: OP_DIV};
          opa = ssd;
          opb = count64 - 64'd1;
          state_next = ST_VSAT;
        end
      end
      ST_VSAT: if (done || count < CountWidth'(2)) begin
        cmd = '{start: 1'b1, op: OP_SQRT};
        opa = (count < CountWidth'(2)) ? 64'd0 :
              (res > 64'hFFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF : res;
        state_next = ST_SQRT;
      end
      ST_SQRT: if (done) state_next = ST_OUT;
      ST_OUT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  logic [63:0] mag;
  logic signed [63:0] q;
  always_comb begin
    mag = res;
    q = d1[63] ? 64'(-mag) : mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      mean <= '0;
      ssd <= '0;
      vmax <= '0;
      vmin <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: if (in_valid && !in_stall) begin
          x <= 64'(in_data.sample);
          if (in_data.restart || count == '0) begin
            count <= CountWidth'(1);
            mean <= 64'(in_data.sample);
            ssd <= '0;
            vmax <= in_data.sample;
            vmin <= in_data.sample;
          end else begin
            if (count != CntMax) count <= count + CountWidth'(1);
            d1 <= 64'(in_data.sample) - mean;
            if (in_data.sample > vmax) vmax <= in_data.sample;
            if (in_data.sample < vmin) vmin <= in_data.sample;
          end
        end
        ST_MEAN: if (done) mean <= mean + q;
        ST_ACC: if (done && same_sign)
          ssd <= (ssd > ~res) ? {64{1'b1}} : ssd + res;
        ST_VSAT: if (done || count < CountWidth'(2))
          var_r <= (count < CountWidth'(2)) ? 64'd0 :
                   (res > 64'hFFFF_FFFF_FFFF) ? 64'hFFFF_FFFF_FFFF : res;
        ST_SQRT: if (done) begin
          out_data.mean_out <= mean[31:0];
          out_data.variance_out <= var_r[47:0];
          out_data.stddev_out <= res[31:0];
          out_data.max_out <= vmax;
          out_data.min_out <= vmin;
          out_data.count_out <= count[31:0];
          out_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  `RMV_ASSERT_IMP(a_no_accept_busy, state != ST_IDLE, in_stall, "accepted while busy")
  `RMV_ASSERT_NEXT(a_hold_out, out_valid && out_stall, out_valid && $stable(out_data),
    "result beat dropped")
  `RMV_ASSERT_IMP(a_order, vmax < vmin, state != ST_IDLE, "max below min")
  `RMV_ASSERT_IMP(a_cmd_state, cmd.start, state != ST_IDLE && state != ST_OUT,
    "unit started out of sequence")
endmodule

>>> bench/running_mean_variance_minmax_tb.sv
// Testbench: random and directed samples checked against a Welford statistics model.
module running_mean_variance_minmax_tb import rmvm_pkg::*;;
  localparam longint unsigned CntMax = 64'hFFFF_FFFF;
  localparam longint unsigned VarMax = (64'd1 << 48) - 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  rmvm_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rmvm_out_t out_data;

  running_mean_variance_minmax dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rmvm_in_t pending_samples[$];
  rmvm_out_t expected_stats[$];
  int errors = 0;
  bit drain_hold = 1'b0;
  bit long_hold_req = 1'b0;

  longint unsigned stat_count;
  longint signed stat_mean;
  longint unsigned stat_ssd;
  longint signed stat_max;
  longint signed stat_min;

  function automatic longint unsigned mag(longint signed v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint unsigned prod_shift_sat(longint unsigned a, longint unsigned b);
    logic [127:0] p;
    p = a * b;
    p = p >> FracBits;
    return p[127:64] != 0 ? 64'hFFFF_FFFF_FFFF_FFFF : p[63:0];
  endfunction

  function automatic longint unsigned fixed_sqrt(longint unsigned v);
    logic [71:0] rad;
    logic [71:0] root, rem, trial;
    rad = {8'd0, v} << FracBits;
    root = 0;
    rem = 0;
    for (int pos = 70; pos >= 0; pos -= 2) begin
      rem = (rem << 2) | ((rad >> pos) & 72'd3);
      trial = (root << 2) | 72'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 72'd1;
      end else begin
        root = root << 1;
      end
    end
    return root > 72'hFFFF_FFFF ? 64'hFFFF_FFFF : root[63:0];
  endfunction

  function automatic rmvm_out_t fold_sample(rmvm_in_t it);
    longint signed x, d1, d2, q;
    longint unsigned term, var_v;
    rmvm_out_t r;
    x = longint'(it.sample);
    var_v = 0;
    if (it.restart || stat_count == 0) begin
      stat_count = 1;
      stat_mean = x;
      stat_ssd = 0;
      stat_max = x;
      stat_min = x;
    end else begin
      d1 = x - stat_mean;
      if (stat_count < CntMax) stat_count++;
      q = d1 / longint'(stat_count);
      stat_mean += q;
      d2 = x - stat_mean;
      if ((d1 < 0 && d2 > 0) || (d1 > 0 && d2 < 0)) term = 0;
      else term = prod_shift_sat(mag(d1), mag(d2));
      stat_ssd = (stat_ssd > 64'hFFFF_FFFF_FFFF_FFFF - term) ?
                 64'hFFFF_FFFF_FFFF_FFFF : stat_ssd + term;
      if (x > stat_max) stat_max = x;
      if (x < stat_min) stat_min = x;
    end
    if (stat_count >= 2) begin
      var_v = stat_ssd / (stat_count - 1);
      if (var_v > VarMax) var_v = VarMax;
    end
    r.mean_out = stat_mean[31:0];
    r.variance_out = var_v[47:0];
    r.stddev_out = fixed_sqrt(var_v);
    r.max_out = stat_max[31:0];
    r.min_out = stat_min[31:0];
    r.count_out = stat_count[31:0];
    return r;
  endfunction

  function automatic rmvm_in_t mk_item(logic [31:0] s, logic rs);
    rmvm_in_t t;
    t.sample = s;
    t.restart = rs;
    return t;
  endfunction

  // driver: bursts and gaps, pauses for drain on request
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_stats.push_back(fold_sample(in_data));
        void'(pending_samples.pop_front());
      end
      if (in_valid && in_stall) begin
        // hold beat
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_samples.size() > (in_valid && !in_stall ? 0 : 0) &&
                   !(drain_hold && expected_stats.size() != 0)) begin
        if (pending_samples.size() != 0) begin
          in_data <= pending_samples[0];
          in_valid <= 1'b1;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 20);
            if ($urandom_range(0, 3) != 0) gap_left <= $urandom_range(0, 300);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: own stall pattern plus one long hold-off
  int stall_phase = 0;
  int long_hold = 0;
  bit long_hold_done = 1'b0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_stats.size() == 0) begin
          $display("%0t unexpected result %h", $time, out_data);
          errors++;
        end else begin
          rmvm_out_t e;
          e = expected_stats.pop_front();
          if (e.mean_out !== out_data.mean_out)
            $display("%0t mean exp %h got %h", $time, e.mean_out, out_data.mean_out);
          if (e.variance_out !== out_data.variance_out)
            $display("%0t variance exp %h got %h", $time, e.variance_out,
                     out_data.variance_out);
          if (e.stddev_out !== out_data.stddev_out)
            $display("%0t stddev exp %h got %h", $time, e.stddev_out, out_data.stddev_out);
          if (e.max_out !== out_data.max_out)
            $display("%0t max exp %h got %h", $time, e.max_out, out_data.max_out);
          if (e.min_out !== out_data.min_out)
            $display("%0t min exp %h got %h", $time, e.min_out, out_data.min_out);
          if (e.count_out !== out_data.count_out)
            $display("%0t count exp %h got %h", $time, e.count_out, out_data.count_out);
          if (e !== out_data) errors++;
        end
      end
      if (long_hold_req && !long_hold_done && long_hold == 0) begin
        long_hold <= 3000;
        long_hold_done <= 1'b1;
        out_stall <= 1'b1;
      end else if (long_hold > 1) begin
        long_hold <= long_hold - 1;
        out_stall <= 1'b1;
      end else begin
        if (long_hold == 1) long_hold <= 0;
        stall_phase <= stall_phase + 1;
        case (stall_phase % 2000 < 1000)
          1'b1: out_stall <= ($urandom_range(0, 3) == 0) ? 1'b1 : 1'b0;
          default: out_stall <= 1'b0;
        endcase
      end
    end
  end

  initial begin
    int n;
    logic [31:0] v;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    // directed extremes, restarts, first item without restart
    pending_samples.push_back(mk_item(32'h7FFF_FFFF, 1'b0));
    pending_samples.push_back(mk_item(32'h8000_0000, 1'b0));
    pending_samples.push_back(mk_item(32'h7FFF_FFFF, 1'b0));
    pending_samples.push_back(mk_item(32'h8000_0000, 1'b0));
    pending_samples.push_back(mk_item(32'h0000_0000, 1'b1));
    pending_samples.push_back(mk_item(32'h0000_0001, 1'b0));
    pending_samples.push_back(mk_item(32'hFFFF_FFFF, 1'b0));
    pending_samples.push_back(mk_item(32'h0000_0002, 1'b0));
    pending_samples.push_back(mk_item(32'hFFFF_FFFE, 1'b0));
    pending_samples.push_back(mk_item(32'h0001_0000, 1'b1));
    pending_samples.push_back(mk_item(32'h0001_0000, 1'b0));
    pending_samples.push_back(mk_item(32'h0003_0000, 1'b0));
    pending_samples.push_back(mk_item(32'hFFFF_0000, 1'b0));
    pending_samples.push_back(mk_item(32'h8000_0000, 1'b1));
    pending_samples.push_back(mk_item(32'h8000_0000, 1'b0));
    pending_samples.push_back(mk_item(32'h7FFF_FFFF, 1'b0));
    pending_samples.push_back(mk_item(32'hFFFF_FFFF, 1'b1));
    pending_samples.push_back(mk_item(32'hFFFF_FFFF, 1'b1));
    while (pending_samples.size() != 0) @(posedge clk);
    drain_hold <= 1'b1;
    while (expected_stats.size() != 0) @(posedge clk);
    drain_hold <= 1'b0;
    long_hold_req <= 1'b1;
    for (int i = 0; i < 1400; i++) begin
      case ($urandom_range(0, 3))
        0: v = $urandom;
        1: v = $urandom_range(0, 255) << $urandom_range(0, 24);
        2: v = -($urandom_range(0, 255) << $urandom_range(0, 24));
        default: v = ($urandom_range(0, 1) ? 32'h7FFF_0000 : 32'h8000_0000) ^
                     $urandom_range(0, 65535);
      endcase
      n = $urandom_range(0, 40);
      pending_samples.push_back(mk_item(v, n == 0));
    end
    while (pending_samples.size() != 0 || in_valid) @(posedge clk);
    while (expected_stats.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (errors == 0) $display("running_mean_variance_minmax test passed");
    else $display("running_mean_variance_minmax test failed");
    $finish;
  end

  initial begin
    #20000000;
    $display("running_mean_variance_minmax test failed");
    $finish;
  end
endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/rmvm_pkg.sv
hw/rtl/rmvm_unit.sv
hw/rtl/running_mean_variance_minmax.sv
bench/running_mean_variance_minmax_tb.sv
